// ===== rtl/vc_pkg.sv =====
package vc_pkg;

  localparam int CharW     = 8;
  localparam int LenW      = 6;
  localparam int RowW      = 2;
  localparam int ColW      = 4;
  localparam int EntryW    = 5;
  localparam int KeyRows   = 4;
  localparam int RowEntries = 12;
  localparam int KeyRegW   = 60;
  localparam int CfgIdxW   = 3;

  localparam logic [CharW-1:0]  UpperFirst = 8'd65;
  localparam logic [CharW-1:0]  UpperLast  = 8'd90;
  localparam logic [CharW-1:0]  LowerFirst = 8'd97;
  localparam logic [CharW-1:0]  LowerLast  = 8'd122;
  localparam logic [EntryW:0]   Alpha      = 6'd26;
  localparam logic [ColW-1:0]   LastCol    = 4'd11;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECRYPT_MODE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_SHIFTS_0 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_SHIFTS_1 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_SHIFTS_2 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_KEY_SHIFTS_3 = 3'd5;

  typedef logic [KeyRows-1:0][KeyRegW-1:0] key_bank_t;

  // key position split into a 12-entry row and a column within it
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } key_pos_t;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             message_start;
    logic             message_end_in;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             message_end_out;
  } out_t;

endpackage

// ===== rtl/vc_key_seq.sv =====
module vc_key_seq #(
  parameter int MAX_KEY_LEN = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     start,
  input  logic [vc_pkg::LenW-1:0]  key_length,
  output vc_pkg::key_pos_t         pos_use,
  output vc_pkg::key_pos_t         pos_q
);

  vc_pkg::key_pos_t        pos_r;
  vc_pkg::key_pos_t        pos_nxt;
  logic [vc_pkg::LenW-1:0] len_eff;
  logic [vc_pkg::LenW-1:0] pos_lin;
  logic [vc_pkg::LenW-1:0] pos_inc;

  assign pos_q   = pos_r;
  assign pos_use = start ? '0 : pos_r;

  always_comb begin
    if (key_length == '0) begin
      len_eff = vc_pkg::LenW'(1);
    end else if (key_length > vc_pkg::LenW'(MAX_KEY_LEN)) begin
      len_eff = vc_pkg::LenW'(MAX_KEY_LEN);
    end else begin
      len_eff = key_length;
    end
  end

  // linear position = row*12 + col
  assign pos_lin = {1'b0, pos_use.row, 3'b000} + {2'b00, pos_use.row, 2'b00}
                 + {2'b00, pos_use.col};
  assign pos_inc = pos_lin + vc_pkg::LenW'(1);

  always_comb begin
    pos_nxt = pos_r;
    if (adv) begin
      if (pos_inc >= len_eff) begin
        pos_nxt = '0;
      end else if (pos_use.col == vc_pkg::LastCol) begin
        pos_nxt.row = pos_use.row + vc_pkg::RowW'(1);
        pos_nxt.col = '0;
      end else begin
        pos_nxt.row = pos_use.row;
        pos_nxt.col = pos_use.col + vc_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/vc_cipher.sv =====
module vc_cipher (
  input  logic [vc_pkg::CharW-1:0] char_in,
  input  vc_pkg::key_pos_t         pos,
  input  vc_pkg::key_bank_t        key_bank,
  input  logic                     decrypt,
  output logic [vc_pkg::CharW-1:0] char_out
);

  logic [5:0]                  bit_off;
  logic [vc_pkg::EntryW-1:0]   raw;
  logic [vc_pkg::EntryW:0]     k_mod;
  logic [vc_pkg::EntryW:0]     k_dir;
  logic [vc_pkg::CharW-1:0]    base;
  logic                        is_letter;
  logic [vc_pkg::EntryW:0]     rel;
  logic [vc_pkg::EntryW:0]     sum;
  logic [vc_pkg::EntryW:0]     sum_mod;

  assign bit_off = {pos.col, 2'b00} + {2'b00, pos.col};
  assign raw     = key_bank[pos.row][bit_off +: vc_pkg::EntryW];

  // 5-bit entry mod 26: values 26..31 fold to 0..5
  assign k_mod = ({1'b0, raw} >= vc_pkg::Alpha) ? ({1'b0, raw} - vc_pkg::Alpha)
                                                : {1'b0, raw};
  assign k_dir = (decrypt && k_mod != '0) ? (vc_pkg::Alpha - k_mod) : k_mod;

  always_comb begin
    is_letter = 1'b1;
    base      = vc_pkg::UpperFirst;
    if (char_in >= vc_pkg::UpperFirst && char_in <= vc_pkg::UpperLast) begin
      base = vc_pkg::UpperFirst;
    end else if (char_in >= vc_pkg::LowerFirst && char_in <= vc_pkg::LowerLast) begin
      base = vc_pkg::LowerFirst;
    end else begin
      is_letter = 1'b0;
    end
  end

  assign rel     = (vc_pkg::EntryW+1)'(char_in - base);
  assign sum     = rel + k_dir;
  assign sum_mod = (sum >= vc_pkg::Alpha) ? (sum - vc_pkg::Alpha) : sum;

  assign char_out = is_letter ? (base + {2'b00, sum_mod}) : char_in;

endmodule

// ===== rtl/vigenere_cipher.sv =====
// vigenere_cipher: per-byte Vigenere shift of ASCII letters.
// Path from input transaction to out_valid: input register, then result register.
// Throughput: one transaction per cycle; both stages advance together when the result
//   register is empty or being taken, so the cipher path adds no bubbles.
// Reset (rst_n low, synchronous): pipeline emptied, key position 0, key_length 1,
//   decrypt_mode 0, all key shifts 0.
module vigenere_cipher #(
  parameter int MAX_KEY_LEN = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vc_pkg::in_t                 in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vc_pkg::out_t                out_data,
  input  logic                        cfg_we,
  input  logic [vc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vc_pkg::KeyRegW-1:0]  cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [vc_pkg::LenW-1:0] key_length_r;
  logic                    decrypt_r;
  vc_pkg::key_bank_t       key_bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= vc_pkg::LenW'(1);
      decrypt_r    <= 1'b0;
      key_bank_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vc_pkg::CFG_KEY_LENGTH:   key_length_r  <= cfg_wdata[vc_pkg::LenW-1:0];
        vc_pkg::CFG_DECRYPT_MODE: decrypt_r     <= cfg_wdata[0];
        vc_pkg::CFG_KEY_SHIFTS_0: key_bank_r[0] <= cfg_wdata;
        vc_pkg::CFG_KEY_SHIFTS_1: key_bank_r[1] <= cfg_wdata;
        vc_pkg::CFG_KEY_SHIFTS_2: key_bank_r[2] <= cfg_wdata;
        vc_pkg::CFG_KEY_SHIFTS_3: key_bank_r[3] <= cfg_wdata;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 (input register) feeds the result register.
  // The result register takes a new value when empty or when the current one
  // is taken; stage 1 refills under the same condition or when empty.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [vc_pkg::CharW-1:0] s1_char_r;
  logic             s1_end_r;
  vc_pkg::key_pos_t s1_pos_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  vc_pkg::out_t     out_data_r;

  logic             out_load;
  logic             in_fire;

  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  // key position tracks every accepted byte; the position in use is captured
  // alongside the byte so the cipher stage needs no state of its own
  vc_pkg::key_pos_t pos_use;
  vc_pkg::key_pos_t pos_q;

  vc_key_seq #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_key_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (in_fire),
    .start      (in_data.message_start),
    .key_length (key_length_r),
    .pos_use    (pos_use),
    .pos_q      (pos_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_data.char_in;
      s1_end_r  <= in_data.message_end_in;
      s1_pos_r  <= pos_use;
    end
  end

  // ---------------------------------------------------------------------------
  // Cipher stage: key entry select, mod-26 shift, into the result register
  // ---------------------------------------------------------------------------
  logic [vc_pkg::CharW-1:0] cipher_char;

  vc_cipher u_cipher (
    .char_in  (s1_char_r),
    .pos      (s1_pos_r),
    .key_bank (key_bank_r),
    .decrypt  (decrypt_r),
    .char_out (cipher_char)
  );

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_data_r.char_out        <= cipher_char;
      out_data_r.message_end_out <= s1_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // key position stays inside its row and below MAX_KEY_LEN entries
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_q.col <= vc_pkg::LastCol) &&
    ((32'(pos_q.row) * 12 + 32'(pos_q.col)) < MAX_KEY_LEN))
    else $error("key position out of range");

  // a message start always enciphers with key entry 0
  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.message_start |=> s1_pos_r == '0)
    else $error("message start did not reset key position");

  // bytes outside A-Z / a-z pass through unchanged
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && s1_valid_r &&
    !((s1_char_r >= vc_pkg::UpperFirst && s1_char_r <= vc_pkg::UpperLast) ||
      (s1_char_r >= vc_pkg::LowerFirst && s1_char_r <= vc_pkg::LowerLast))
    |=> out_data_r.char_out == $past(s1_char_r))
    else $error("non-letter byte altered");

  // an empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
